>>> rtl/cpsig_pkg.sv
// Shared types, constants and lookup tables of the convolution / pooling synapse generator.
package cpsig_pkg;

    localparam int MAX_DIM    = 256;
    localparam int MAX_KERN   = 16;
    localparam int MAX_CHAN   = 1024;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 11;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_IN_ROWS    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_IN_COLS    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_IN_CHANS   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_KERN_ROWS  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_KERN_COLS  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_STRIDE_ROW = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_STRIDE_COL = 3'd7;

    localparam logic MODE_CONV = 1'b0;
    localparam logic MODE_POOL = 1'b1;

    typedef struct packed {
        logic        start_req;
        logic [31:0] first_input_id;
        logic [10:0] filter_count;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] src_id;
        logic [31:0] dst_id;
        logic [27:0] weight_index;
        logic        has_weight;
        logic [7:0]  out_row;
        logic [7:0]  out_col;
        logic        window_last;
        logic        layer_last;
    } t_out;

    // effective (clamped) configuration
    typedef struct packed {
        logic        mode;
        logic [8:0]  rows;
        logic [8:0]  cols;
        logic [10:0] chw;
        logic [10:0] ch;
        logic [4:0]  kr;
        logic [4:0]  kc;
        logic [4:0]  sr;
        logic [4:0]  sc;
    } t_cfg;

    // counter snapshot taken when a request is accepted
    typedef struct packed {
        logic        is_start;
        logic        active;
        logic [31:0] base;
        logic [31:0] ofs;
        logic [9:0]  fi;
        logic [9:0]  k;
        logic [3:0]  ki;
        logic [3:0]  kj;
        logic [7:0]  wre;
        logic [7:0]  wce;
        logic [10:0] ftot;
        logic        wl;
        logic        ll;
    } t_snap;

    function automatic logic [8:0] f_clamp_dim(input logic [8:0] v);
        return (v > 9'(MAX_DIM)) ? 9'(MAX_DIM) : v;
    endfunction

    function automatic logic [4:0] f_clamp_kern(input logic [4:0] v);
        return (v > 5'(MAX_KERN)) ? 5'(MAX_KERN) : v;
    endfunction

    function automatic logic [10:0] f_clamp_chan(input logic [10:0] v);
        return (v > 11'(MAX_CHAN)) ? 11'(MAX_CHAN) : v;
    endfunction

    function automatic logic [4:0] f_eff_stride(input logic [4:0] v);
        logic [4:0] c;
        c = f_clamp_kern(v);
        return (c == 5'd0) ? 5'd1 : c;
    endfunction

    // floor(2^16 / s) + 1: exact quotient for numerators below 512
    function automatic logic [16:0] f_recip(input logic [4:0] s);
        logic [16:0] r;
        case (s)
            5'd1:    r = 17'd65537;
            5'd2:    r = 17'd32769;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16385;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8193;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4097;
            default: r = 17'd65537;
        endcase
        return r;
    endfunction

    // low byte of floor(2^64 / s)
    function automatic logic [7:0] f_wrap_qlo(input logic [4:0] s);
        logic [7:0] r;
        case (s)
            5'd3:    r = 8'h55;
            5'd5:    r = 8'h33;
            5'd6:    r = 8'hAA;
            5'd7:    r = 8'h92;
            5'd9:    r = 8'h71;
            5'd10:   r = 8'h99;
            5'd11:   r = 8'hD1;
            5'd12:   r = 8'h55;
            5'd13:   r = 8'hB1;
            5'd14:   r = 8'h49;
            5'd15:   r = 8'h11;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // 2^64 mod s
    function automatic logic [3:0] f_wrap_rem(input logic [4:0] s);
        logic [3:0] r;
        case (s)
            5'd3:    r = 4'd1;
            5'd5:    r = 4'd1;
            5'd6:    r = 4'd4;
            5'd7:    r = 4'd2;
            5'd9:    r = 4'd7;
            5'd10:   r = 4'd6;
            5'd11:   r = 4'd5;
            5'd12:   r = 4'd4;
            5'd13:   r = 4'd3;
            5'd14:   r = 4'd2;
            5'd15:   r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/cpsig_calc.sv
// Three-stage datapath: ids, weight index and window position from a counter snapshot.
module cpsig_calc
    import cpsig_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_snap i_snap,
    output logic  o_valid,
    output t_out  o_res
);

    typedef struct packed {
        logic       neg;
        logic [8:0] q;
        logic [7:0] qlo;
    } t_div;

    typedef struct packed {
        logic               is_start;
        logic               active;
        logic [31:0]        base;
        logic [31:0]        ofs;
        logic [9:0]         fi;
        logic [9:0]         k;
        logic [10:0]        ftot;
        logic               wl;
        logic               ll;
        logic [16:0]        rc;
        logic signed [19:0] rowc;
        logic signed [9:0]  colv;
        logic [9:0]         wk1;
        t_div               rdiv;
        t_div               cdiv;
    } t_sa;

    typedef struct packed {
        logic        is_start;
        logic        active;
        logic [31:0] base;
        logic [31:0] ofs;
        logic [9:0]  fi;
        logic [10:0] ftot;
        logic        wl;
        logic        ll;
        logic [26:0] prc;
        logic [31:0] rowcol;
        logic [21:0] wk2;
        logic [27:0] rcch;
        logic [7:0]  orow;
        logic [7:0]  ocol;
    } t_sb;

    // window origin divided by the stride; a negative origin is taken modulo 2^64
    function automatic t_div f_div_prep(input logic signed [9:0] r0, input logic [4:0] s);
        t_div        res;
        logic [4:0]  d;
        logic [3:0]  m;
        logic [8:0]  v;
        logic [25:0] p;
        m = f_wrap_rem(s);
        d = 5'(-r0);
        if (r0[9]) begin
            v = (d > {1'b0, m}) ? (9'(d) - 9'(m) + 9'(s) - 9'd1) : 9'd0;
        end else begin
            v = r0[8:0];
        end
        p = 26'(v) * 26'(f_recip(s));
        res.neg = r0[9];
        res.q   = p[24:16];
        res.qlo = f_wrap_qlo(s);
        return res;
    endfunction

    t_sa         r_sa, n_sa;
    t_sb         r_sb, n_sb;
    logic        r_sa_vld, r_sb_vld;
    logic [31:0] r_dest_base;

    logic signed [9:0] a_r0, a_c0, a_rsum, a_csum;
    logic [9:0]        b_plane;
    logic [31:0]       c_wi, c_src, c_dst;

    // stage A
    always_comb begin
        a_r0   = signed'({2'b00, i_snap.wre} + 10'd1 - {5'b00000, i_cfg.kr});
        a_c0   = signed'({2'b00, i_snap.wce} + 10'd1 - {5'b00000, i_cfg.kc});
        a_rsum = a_r0 + signed'({6'b000000, i_snap.ki});
        a_csum = a_c0 + signed'({6'b000000, i_snap.kj});

        n_sa.is_start = i_snap.is_start;
        n_sa.active   = i_snap.active;
        n_sa.base     = i_snap.base;
        n_sa.ofs      = i_snap.ofs;
        n_sa.fi       = i_snap.fi;
        n_sa.k        = i_snap.k;
        n_sa.ftot     = i_snap.ftot;
        n_sa.wl       = i_snap.wl;
        n_sa.ll       = i_snap.ll;
        n_sa.rc       = 17'(i_cfg.rows) * 17'(i_cfg.cols);
        n_sa.rowc     = a_rsum * signed'({1'b0, i_cfg.cols});
        n_sa.colv     = a_csum;
        n_sa.wk1      = 10'(i_snap.ki) * 10'(i_cfg.kc) + 10'(i_snap.kj);
        n_sa.rdiv     = f_div_prep(a_r0, i_cfg.sr);
        n_sa.cdiv     = f_div_prep(a_c0, i_cfg.sc);
    end

    // stage B
    always_comb begin
        b_plane = (i_cfg.mode == MODE_POOL) ? r_sa.fi : r_sa.k;

        n_sb.is_start = r_sa.is_start;
        n_sb.active   = r_sa.active;
        n_sb.base     = r_sa.base;
        n_sb.ofs      = r_sa.ofs;
        n_sb.fi       = r_sa.fi;
        n_sb.ftot     = r_sa.ftot;
        n_sb.wl       = r_sa.wl;
        n_sb.ll       = r_sa.ll;
        n_sb.prc      = 27'(b_plane) * 27'(r_sa.rc);
        n_sb.rowcol   = {{12{r_sa.rowc[19]}}, r_sa.rowc} + {{22{r_sa.colv[9]}}, r_sa.colv};
        n_sb.wk2      = 22'(r_sa.wk1) * 22'(i_cfg.chw) + 22'(r_sa.k);
        n_sb.rcch     = 28'(r_sa.rc) * 28'(i_cfg.chw);
        n_sb.orow     = r_sa.rdiv.neg ? (r_sa.rdiv.qlo - r_sa.rdiv.q[7:0]) : r_sa.rdiv.q[7:0];
        n_sb.ocol     = r_sa.cdiv.neg ? (r_sa.cdiv.qlo - r_sa.cdiv.q[7:0]) : r_sa.cdiv.q[7:0];
    end

    // stage C: starts load the destination base here, requests read it here
    always_comb begin
        c_wi  = 32'(r_sb.wk2) * 32'(r_sb.ftot) + 32'(r_sb.fi);
        c_src = r_sb.base + 32'(r_sb.prc) + r_sb.rowcol;
        c_dst = r_dest_base + r_sb.ofs;

        o_res = '0;
        if (r_sb.active) begin
            o_res.valid_res    = 1'b1;
            o_res.src_id       = c_src;
            o_res.dst_id       = c_dst;
            o_res.weight_index = (i_cfg.mode == MODE_POOL) ? 28'd0 : c_wi[27:0];
            o_res.has_weight   = (i_cfg.mode == MODE_CONV);
            o_res.out_row      = r_sb.orow;
            o_res.out_col      = r_sb.ocol;
            o_res.window_last  = r_sb.wl;
            o_res.layer_last   = r_sb.ll;
        end
        o_valid = r_sb_vld && !r_sb.is_start;
    end

    always_ff @(posedge i_clk) begin
        r_sa <= n_sa;
        r_sb <= n_sb;
        if (!i_rst_n) begin
            r_sa_vld    <= 1'b0;
            r_sb_vld    <= 1'b0;
            r_dest_base <= '0;
        end else begin
            r_sa_vld <= i_valid;
            r_sb_vld <= r_sa_vld;
            if (r_sb_vld && r_sb.is_start) begin
                r_dest_base <= r_sb.base + 32'(r_sb.rcch);
            end
        end
    end

    a_ll_implies_wl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.layer_last) |-> o_res.window_last)
        else $error("layer_last without window_last");

    a_weight_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.has_weight) |-> o_res.valid_res)
        else $error("weight reported for finished walk");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_sa_vld))
        else $error("result without an item in stage A");

endmodule

>>> rtl/conv_pool_synapse_index_generator_core.sv
// Top level: configuration registers, walk counters, datapath and result FIFO.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): a request with
//   start_req set loads the first input id and the filter count (in pool
//   mode the channel count) and gives no result; a request with start_req
//   clear returns the next synapse of the walk, or valid_res 0 when done.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one result per
//   non-start request, in order.
//   An accepted request is registered as a snapshot, passes datapath stages
//   A and B, and its result is written into the FIFO. Throughput: one request
//   per cycle sustained while o_in_stall is low; the walk counters advance
//   with each accepted request and the three-stage datapath (one multiplier
//   level per stage) is fully pipelined. Configuration writes (i_cfg_wr_en /
//   i_cfg_addr / i_cfg_wr_data) act at once; the user must make them only when
//   no request of either kind is in flight, which the block does not enforce.
//   Reset clears the walk state, the pipeline and the FIFO; registers return
//   to mode 0 and all sizes 1.
//   When the receiver stalls, up to 8 results are held; o_in_stall rises
//   once 8 non-start requests are in flight or waiting.
module conv_pool_synapse_index_generator_core
    import cpsig_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wr_data
);

    // configuration registers
    logic        r_mode;
    logic [8:0]  r_in_rows, r_in_cols;
    logic [10:0] r_in_chans;
    logic [4:0]  r_kern_rows, r_kern_cols, r_stride_row, r_stride_col;

    // walk state
    logic        r_active, n_active;
    logic [31:0] r_base, n_base;
    logic [31:0] r_ofs, n_ofs;
    logic [10:0] r_ftot, n_ftot;
    logic [9:0]  r_fi, n_fi;
    logic [7:0]  r_wre, n_wre;
    logic [7:0]  r_wce, n_wce;
    logic [9:0]  r_k, n_k;
    logic [3:0]  r_ki, n_ki;
    logic [3:0]  r_kj, n_kj;

    t_snap       r_snap, n_snap;
    logic        r_snap_vld;

    // result FIFO and in-flight request count
    t_out                r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]  r_fcnt, r_occ;

    t_cfg        cfg_eff;
    logic        in_acc, out_acc, dp_valid;
    t_out        dp_res;
    logic [4:0]  fe_kj1, fe_ki1;
    logic [10:0] fe_k1, fe_fi1, fe_fc;
    logic [8:0]  fe_nr, fe_nc;
    logic [7:0]  fe_kr1, fe_kc1;
    logic        kj_end, ki_end, k_end, f_end, r_end, c_end;
    logic        fe_wl, fe_ll, fe_start_act;

    always_comb begin
        cfg_eff.mode = r_mode;
        cfg_eff.rows = f_clamp_dim(r_in_rows);
        cfg_eff.cols = f_clamp_dim(r_in_cols);
        cfg_eff.chw  = f_clamp_chan(r_in_chans);
        cfg_eff.ch   = (r_mode == MODE_POOL) ? 11'd1 : f_clamp_chan(r_in_chans);
        cfg_eff.kr   = f_clamp_kern(r_kern_rows);
        cfg_eff.kc   = f_clamp_kern(r_kern_cols);
        cfg_eff.sr   = f_eff_stride(r_stride_row);
        cfg_eff.sc   = f_eff_stride(r_stride_col);
    end

    assign o_in_stall  = (r_occ == FIFO_CW'(FIFO_DEPTH));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_fcnt != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_data  = r_fifo[r_rd_ptr];

    // end-of-loop tests against the live configuration
    always_comb begin
        fe_kj1 = {1'b0, r_kj} + 5'd1;
        fe_ki1 = {1'b0, r_ki} + 5'd1;
        fe_k1  = {1'b0, r_k} + 11'd1;
        fe_fi1 = {1'b0, r_fi} + 11'd1;
        fe_nr  = {1'b0, r_wre} + {4'b0000, cfg_eff.sr};
        fe_nc  = {1'b0, r_wce} + {4'b0000, cfg_eff.sc};
        fe_kr1 = {3'b000, cfg_eff.kr} - 8'd1;
        fe_kc1 = {3'b000, cfg_eff.kc} - 8'd1;
        kj_end = (fe_kj1 >= cfg_eff.kc);
        ki_end = (fe_ki1 >= cfg_eff.kr);
        k_end  = (fe_k1 >= cfg_eff.ch);
        f_end  = (fe_fi1 >= r_ftot);
        r_end  = (fe_nr >= cfg_eff.rows);
        c_end  = (fe_nc >= cfg_eff.cols);
        fe_wl  = k_end && ki_end && kj_end;
        fe_ll  = fe_wl && f_end && r_end && c_end;
        fe_fc  = (r_mode == MODE_POOL) ? cfg_eff.chw : f_clamp_chan(i_in_data.filter_count);
        fe_start_act = (fe_fc != '0) && (cfg_eff.ch != '0) && (cfg_eff.kr != '0)
                    && (cfg_eff.kc != '0) && ({4'b0000, cfg_eff.kr} <= cfg_eff.rows)
                    && ({4'b0000, cfg_eff.kc} <= cfg_eff.cols);
    end

    always_comb begin
        n_active = r_active;
        n_base   = r_base;
        n_ofs    = r_ofs;
        n_ftot   = r_ftot;
        n_fi     = r_fi;
        n_wre    = r_wre;
        n_wce    = r_wce;
        n_k      = r_k;
        n_ki     = r_ki;
        n_kj     = r_kj;

        n_snap.is_start = i_in_data.start_req;
        n_snap.active   = r_active;
        n_snap.base     = i_in_data.start_req ? i_in_data.first_input_id : r_base;
        n_snap.ofs      = r_ofs;
        n_snap.fi       = r_fi;
        n_snap.k        = r_k;
        n_snap.ki       = r_ki;
        n_snap.kj       = r_kj;
        n_snap.wre      = r_wre;
        n_snap.wce      = r_wce;
        n_snap.ftot     = r_ftot;
        n_snap.wl       = fe_wl;
        n_snap.ll       = fe_ll;

        if (in_acc) begin
            if (i_in_data.start_req) begin
                n_base   = i_in_data.first_input_id;
                n_ofs    = '0;
                n_ftot   = fe_fc;
                n_fi     = '0;
                n_wre    = fe_kr1;
                n_wce    = fe_kc1;
                n_k      = '0;
                n_ki     = '0;
                n_kj     = '0;
                n_active = fe_start_act;
            end else if (r_active) begin
                // innermost to outermost: kernel col, kernel row, channel,
                // output col, output row, filter
                if (!kj_end) begin
                    n_kj = fe_kj1[3:0];
                end else begin
                    n_kj = '0;
                    if (!ki_end) begin
                        n_ki = fe_ki1[3:0];
                    end else begin
                        n_ki = '0;
                        if (!k_end) begin
                            n_k = fe_k1[9:0];
                        end else begin
                            n_k   = '0;
                            n_ofs = r_ofs + 32'd1;
                            if (!c_end) begin
                                n_wce = fe_nc[7:0];
                            end else begin
                                n_wce = fe_kc1;
                                if (!r_end) begin
                                    n_wre = fe_nr[7:0];
                                end else begin
                                    n_wre = fe_kr1;
                                    if (!f_end) begin
                                        n_fi = fe_fi1[9:0];
                                    end else begin
                                        n_fi     = '0;
                                        n_active = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CONV;
            r_in_rows    <= 9'd1;
            r_in_cols    <= 9'd1;
            r_in_chans   <= 11'd1;
            r_kern_rows  <= 5'd1;
            r_kern_cols  <= 5'd1;
            r_stride_row <= 5'd1;
            r_stride_col <= 5'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_MODE:       r_mode       <= i_cfg_wr_data[0];
                CFG_IN_ROWS:    r_in_rows    <= i_cfg_wr_data[8:0];
                CFG_IN_COLS:    r_in_cols    <= i_cfg_wr_data[8:0];
                CFG_IN_CHANS:   r_in_chans   <= i_cfg_wr_data[10:0];
                CFG_KERN_ROWS:  r_kern_rows  <= i_cfg_wr_data[4:0];
                CFG_KERN_COLS:  r_kern_cols  <= i_cfg_wr_data[4:0];
                CFG_STRIDE_ROW: r_stride_row <= i_cfg_wr_data[4:0];
                CFG_STRIDE_COL: r_stride_col <= i_cfg_wr_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_snap <= n_snap;
        end
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_base     <= '0;
            r_ofs      <= '0;
            r_ftot     <= '0;
            r_fi       <= '0;
            r_wre      <= '0;
            r_wce      <= '0;
            r_k        <= '0;
            r_ki       <= '0;
            r_kj       <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_base     <= n_base;
            r_ofs      <= n_ofs;
            r_ftot     <= n_ftot;
            r_fi       <= n_fi;
            r_wre      <= n_wre;
            r_wce      <= n_wce;
            r_k        <= n_k;
            r_ki       <= n_ki;
            r_kj       <= n_kj;
            r_snap_vld <= in_acc;
        end
    end

    cpsig_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_eff),
        .i_valid (r_snap_vld),
        .i_snap  (r_snap),
        .o_valid (dp_valid),
        .o_res   (dp_res)
    );

    always_ff @(posedge i_clk) begin
        if (dp_valid) begin
            r_fifo[r_wr_ptr] <= dp_res;
        end
    end

    // r_occ counts non-start requests from acceptance until their result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
            r_occ    <= '0;
        end else begin
            if (dp_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fcnt <= r_fcnt + FIFO_CW'(dp_valid) - FIFO_CW'(out_acc);
            r_occ  <= r_occ + FIFO_CW'(in_acc && !i_in_data.start_req) - FIFO_CW'(out_acc);
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FIFO_CW'(FIFO_DEPTH))
        else $error("in-flight request count above FIFO depth");

    a_fifo_within_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_occ)
        else $error("FIFO holds more results than requests in flight");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.start_req && r_active && fe_ll) |=> !r_active)
        else $error("walk still active after its last synapse");

endmodule
